>>> rtl/core/waypoint_follow_drive_controller_core_assert.svh
// Assertion macros for the waypoint drive controller port checker.
// Expects clk and rst in the scope of use.
`ifndef WAYPOINT_FOLLOW_DRIVE_CONTROLLER_CORE_ASSERT_SVH
`define WAYPOINT_FOLLOW_DRIVE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define WFDC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("port check failed");

// next-cycle implication
`define WFDC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("port check failed");

`endif

>>> rtl/core/wfdc_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the waypoint
// drive controller. No dependencies.
package wfdc_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int STEP_W           = 5;

  localparam int MUL_AW = 32;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = 48;
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 18;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_POSE  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REG_MAX_SPEED  = 1'b0,
    REG_THETA_GAIN = 1'b1
  } reg_idx_t;

  function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/wfdc_smul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on wfdc_pkg for operand widths.
module wfdc_smul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wfdc_pkg::MUL_AW-1:0]  a,
  input  logic [wfdc_pkg::MUL_BW-1:0]  b,
  output logic                         done,
  output logic [wfdc_pkg::MUL_PW-1:0]  prod
);

  localparam int CNT_W = $clog2(wfdc_pkg::MUL_BW + 1);

  logic [wfdc_pkg::MUL_PW-1:0] mcand;
  logic [wfdc_pkg::MUL_BW-1:0] mplier;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= {{(wfdc_pkg::MUL_PW - wfdc_pkg::MUL_AW){1'b0}}, a};
        mplier <= b;
        prod   <= '0;
        cnt    <= CNT_W'(wfdc_pkg::MUL_BW);
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/wfdc_sdiv.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// Depends on wfdc_pkg for operand widths.
module wfdc_sdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wfdc_pkg::DIV_NW-1:0]  n,
  input  logic [wfdc_pkg::DIV_DW-1:0]  d,
  output logic                         done,
  output logic [wfdc_pkg::DIV_NW-1:0]  q
);

  localparam int CNT_W = $clog2(wfdc_pkg::DIV_NW + 1);

  logic [wfdc_pkg::DIV_DW-1:0] rem;
  logic [wfdc_pkg::DIV_DW-1:0] dv;
  logic [wfdc_pkg::DIV_DW:0]   trial;
  logic                        ge;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;

  assign trial = {rem, q[wfdc_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        dv   <= d;
        q    <= n;
        cnt  <= CNT_W'(wfdc_pkg::DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? wfdc_pkg::DIV_DW'(trial - {1'b0, dv}) : wfdc_pkg::DIV_DW'(trial);
        q   <= {q[wfdc_pkg::DIV_NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/waypoint_follow_drive_controller_core.sv
// Start and end use no arithmetic unit; a load into a non-empty queue that is not
// full squares the step with two serial multiplies. A pose update takes up to three
// passes of the serial divider and up to six serial multiplies, plus the CORDIC loops.
// One beat in flight; the next beat is taken as soon as the result is latched.
// Reset (synchronous, rst high): queue empty, totals, target and last pose zero,
// max_speed 1000, theta_gain 256. Queue memory holds no reset.
module waypoint_follow_drive_controller_core #(
  parameter int QUEUE_DEPTH  = wfdc_pkg::QUEUE_DEPTH_DEF,
  parameter int CORDIC_STEPS = wfdc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               drive_valid,
  output logic signed [14:0] vel_x,
  output logic signed [14:0] vel_y,
  output logic signed [15:0] turn_rate,
  output logic               field_relative,
  output logic               done_res,
  input  logic               cfg_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [wfdc_pkg::STEP_W-1:0] LAST_STEP = wfdc_pkg::STEP_W'(CORDIC_STEPS - 1);

  localparam logic [31:0] GAIN_COMP   = 32'd652032874;
  localparam logic [17:0] DIV_HANG    = 18'd36000;
  localparam logic [17:0] DIV_TURN    = 18'd230400;
  localparam logic [17:0] DIV_RAMP_DN = 18'd750;
  localparam logic [17:0] DIV_RAMP_UP = 18'd500;
  localparam logic [47:0] TURN_BIAS   = 48'd115200;
  localparam logic [15:0] TURN_K      = 16'd157;
  localparam logic [13:0] SPEED_FLOOR = 14'd100;
  localparam logic signed [17:0] HALF_TURN = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;
  localparam logic signed [16:0] REACH_XY  = 17'sd100;
  localparam logic signed [15:0] REACH_H   = 16'sd500;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_SQX, S_SQY, S_ROOT, S_ACC, S_SPEED, S_SPD_MUL, S_SPD_DIV,
    S_HANG, S_BEAR_INIT, S_BEAR, S_KMUL, S_ROT, S_ROT_FIN, S_EH_MUL, S_GAIN_MUL,
    S_TR_DIV, S_OUT
  } state_t;

  state_t state;

  wfdc_pkg::cmd_t    cmd_r;
  logic signed [15:0] px, py, ph;

  logic [12:0] max_speed;
  logic [15:0] theta_gain;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic signed [15:0] prev_x, prev_y, last_x, last_y;
  logic signed [15:0] tgt_x, tgt_y, tgt_h;
  logic [23:0] total, trav;
  logic        fin;

  logic [47:0] mem [QUEUE_DEPTH];
  logic [47:0] rd_data;
  logic        mem_we;
  logic [CW:0] tail_sum;
  logic [AW-1:0] tail, head_inc;

  logic        mul_start, mul_done;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic        div_start, div_done;
  logic [47:0] div_n, div_q;
  logic [17:0] div_d;

  logic [15:0] dmx, dmy;
  logic [33:0] rv, rr, rb;
  logic [34:0] root_trial;
  logic [24:0] acc_sum;
  logic [23:0] acc_sat;

  logic        sel_up;
  logic [13:0] speed;
  logic [31:0] hang, ang;
  logic        flip;
  logic signed [33:0] cx, cy, cz;
  logic [wfdc_pkg::STEP_W-1:0] idx;

  wfdc_pkg::status_t w_status;
  logic        w_drv, w_fr;
  logic signed [14:0] w_vx, w_vy;
  logic signed [15:0] w_tr;

  // comb helpers
  logic signed [16:0] ex, ey, sdx, sdy, bdx, bdy, mgx, mgy, bx, by;
  logic signed [17:0] eh_raw, eh_w;
  logic signed [15:0] eh;
  logic [14:0]        eh_abs;
  logic [15:0]        ph_abs;
  logic               reached;
  logic [23:0]        remain;
  logic signed [33:0] xs, ys, at;
  logic               ccw;
  logic signed [33:0] rxs, rys;
  logic signed [18:0] rx, ry;
  logic [31:0]        ang_sum, ang_f;

  function automatic logic signed [14:0] sat15(input logic signed [18:0] v);
    logic signed [14:0] r;
    if (v > 19'sd16383) begin
      r = 15'sd16383;
    end else if (v < -19'sd16384) begin
      r = -15'sd16384;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  wfdc_smul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  wfdc_sdiv u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(div_d),
    .done(div_done), .q(div_q)
  );

  assign in_ready = (state == S_IDLE);

  assign tail_sum = {1'b0, CW'(head)} + {1'b0, count};
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign mem_we   = (state == S_DEC) && (cmd_r == wfdc_pkg::CMD_LOAD) && (count != DEPTH_C);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= {px, py, ph};
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= 13'd1000;
      theta_gain <= 16'd256;
    end else if (cfg_en) begin
      case (wfdc_pkg::reg_idx_t'(cfg_index))
        wfdc_pkg::REG_MAX_SPEED:  max_speed  <= cfg_data[12:0];
        wfdc_pkg::REG_THETA_GAIN: theta_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ex     = $signed({tgt_x[15], tgt_x}) - $signed({px[15], px});
    ey     = $signed({tgt_y[15], tgt_y}) - $signed({py[15], py});
    eh_raw = $signed({{2{tgt_h[15]}}, tgt_h}) - $signed({{2{ph[15]}}, ph});
    if (eh_raw > HALF_TURN) begin
      eh_w = eh_raw - FULL_TURN;
    end else if (eh_raw < -HALF_TURN) begin
      eh_w = eh_raw + FULL_TURN;
    end else begin
      eh_w = eh_raw;
    end
    eh      = eh_w[15:0];
    eh_abs  = eh[15] ? 15'(-eh) : eh[14:0];
    ph_abs  = ph[15] ? 16'(-ph) : ph;
    reached = (ex > -REACH_XY) && (ex < REACH_XY) && (ey > -REACH_XY) && (ey < REACH_XY)
              && (eh > -REACH_H) && (eh < REACH_H);

    if (cmd_r == wfdc_pkg::CMD_LOAD) begin
      sdx = $signed({prev_x[15], prev_x}) - $signed({px[15], px});
      sdy = $signed({prev_y[15], prev_y}) - $signed({py[15], py});
    end else begin
      sdx = $signed({last_x[15], last_x}) - $signed({px[15], px});
      sdy = $signed({last_y[15], last_y}) - $signed({py[15], py});
    end
    mgx = sdx[16] ? -sdx : sdx;
    mgy = sdy[16] ? -sdy : sdy;

    bdx = ex;
    bdy = ey;
    bx  = bdx[16] ? -bdx : bdx;
    by  = bdx[16] ? -bdy : bdy;

    root_trial = {1'b0, rr} + {1'b0, rb};
    acc_sum    = {1'b0, (cmd_r == wfdc_pkg::CMD_LOAD) ? total : trav} + 25'(rr[17:0]);
    acc_sat    = acc_sum[24] ? 24'hFFFFFF : acc_sum[23:0];
    remain     = total - trav;

    xs  = cx >>> idx;
    ys  = cy >>> idx;
    at  = $signed({2'b00, wfdc_pkg::atan_val(idx)});
    ccw = (state == S_ROT) ? !cz[33] : cy[33];

    rxs = cx + 34'sd32768;
    rys = cy + 34'sd32768;
    rx  = flip ? -$signed({rxs[33], rxs[33:16]}) : $signed({rxs[33], rxs[33:16]});
    ry  = flip ? -$signed({rys[33], rys[33:16]}) : $signed({rys[33], rys[33:16]});

    ang_sum = ang + 32'h4000_0000;
    ang_f   = ang ^ {ang_sum[31], 31'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      head      <= '0;
      count     <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      last_x    <= '0;
      last_y    <= '0;
      tgt_x     <= '0;
      tgt_y     <= '0;
      tgt_h     <= '0;
      total     <= '0;
      trav      <= '0;
      fin       <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= wfdc_pkg::cmd_t'(cmd);
            px    <= pos_x;
            py    <= pos_y;
            ph    <= heading;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          w_status <= wfdc_pkg::ST_OK;
          w_drv    <= 1'b0;
          w_fr     <= 1'b0;
          w_vx     <= '0;
          w_vy     <= '0;
          w_tr     <= '0;
          dmx      <= mgx[15:0];
          dmy      <= mgy[15:0];
          mul_a    <= {16'b0, mgx[15:0]};
          mul_b    <= mgx[15:0];
          state    <= S_OUT;
          case (cmd_r)
            wfdc_pkg::CMD_LOAD: begin
              if (count == DEPTH_C) begin
                w_status <= wfdc_pkg::ST_FULL;
              end else begin
                prev_x <= px;
                prev_y <= py;
                count  <= count + 1'b1;
                if (count != '0) begin
                  mul_start <= 1'b1;
                  state     <= S_SQX;
                end
              end
            end
            wfdc_pkg::CMD_START: begin
              if (count == '0) begin
                w_status <= wfdc_pkg::ST_EMPTY;
              end else begin
                tgt_x <= rd_data[47:32];
                tgt_y <= rd_data[31:16];
                tgt_h <= rd_data[15:0];
                head  <= head_inc;
                count <= count - 1'b1;
              end
            end
            wfdc_pkg::CMD_POSE: begin
              if (reached) begin
                if (count != '0) begin
                  tgt_x <= rd_data[47:32];
                  tgt_y <= rd_data[31:16];
                  tgt_h <= rd_data[15:0];
                  head  <= head_inc;
                  count <= count - 1'b1;
                end else begin
                  fin <= 1'b1;
                end
              end
              last_x    <= px;
              last_y    <= py;
              mul_start <= 1'b1;
              state     <= S_SQX;
            end
            wfdc_pkg::CMD_END: begin
              trav  <= '0;
              total <= '0;
              fin   <= 1'b0;
              w_drv <= 1'b1;
              w_fr  <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SQX: begin
          if (mul_done) begin
            rv        <= mul_p[33:0];
            mul_a     <= {16'b0, dmy};
            mul_b     <= dmy;
            mul_start <= 1'b1;
            state     <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            rv    <= rv + mul_p[33:0];
            rr    <= '0;
            rb    <= 34'h1_0000_0000;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if ({1'b0, rv} >= root_trial) begin
            rv <= 34'(rv - root_trial[33:0]);
            rr <= (rr >> 1) + rb;
          end else begin
            rr <= rr >> 1;
          end
          rb <= rb >> 2;
          if (rb[0]) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (cmd_r == wfdc_pkg::CMD_LOAD) begin
            total <= acc_sat;
            state <= S_OUT;
          end else begin
            trav  <= acc_sat;
            state <= fin ? S_OUT : S_SPEED;
          end
        end
        S_SPEED: begin
          div_n <= {ph_abs, 32'b0};
          div_d <= DIV_HANG;
          mul_b <= {3'b0, max_speed};
          if (trav >= total) begin
            speed     <= SPEED_FLOOR;
            div_start <= 1'b1;
            state     <= S_HANG;
          end else if (remain <= 24'd750) begin
            mul_a     <= {8'b0, remain};
            sel_up    <= 1'b0;
            mul_start <= 1'b1;
            state     <= S_SPD_MUL;
          end else if (trav <= 24'd500) begin
            mul_a     <= {8'b0, trav};
            sel_up    <= 1'b1;
            mul_start <= 1'b1;
            state     <= S_SPD_MUL;
          end else begin
            speed     <= {1'b0, max_speed};
            div_start <= 1'b1;
            state     <= S_HANG;
          end
        end
        S_SPD_MUL: begin
          if (mul_done) begin
            div_n     <= mul_p;
            div_d     <= sel_up ? DIV_RAMP_UP : DIV_RAMP_DN;
            div_start <= 1'b1;
            state     <= S_SPD_DIV;
          end
        end
        S_SPD_DIV: begin
          if (div_done) begin
            speed     <= div_q[13:0] + (sel_up ? SPEED_FLOOR : 14'd0);
            div_n     <= {ph_abs, 32'b0};
            div_d     <= DIV_HANG;
            div_start <= 1'b1;
            state     <= S_HANG;
          end
        end
        S_HANG: begin
          if (div_done) begin
            hang  <= ph[15] ? 32'(-div_q[31:0]) : div_q[31:0];
            state <= S_BEAR_INIT;
          end
        end
        S_BEAR_INIT: begin
          mul_a <= GAIN_COMP;
          mul_b <= {2'b0, speed};
          idx   <= '0;
          if (bdx == '0 && bdy == '0) begin
            ang       <= 32'(-hang);
            mul_start <= 1'b1;
            state     <= S_KMUL;
          end else begin
            cx    <= $signed({{3{bx[16]}}, bx, 14'b0});
            cy    <= $signed({{3{by[16]}}, by, 14'b0});
            cz    <= bdx[16] ? 34'sh0_8000_0000 : 34'sd0;
            state <= S_BEAR;
          end
        end
        S_BEAR: begin
          cx  <= ccw ? cx - ys : cx + ys;
          cy  <= ccw ? cy + xs : cy - xs;
          cz  <= ccw ? cz - at : cz + at;
          idx <= idx + 1'b1;
          if (idx == LAST_STEP) begin
            ang       <= (ccw ? cz[31:0] - at[31:0] : cz[31:0] + at[31:0]) - hang;
            mul_start <= 1'b1;
            state     <= S_KMUL;
          end
        end
        S_KMUL: begin
          if (mul_done) begin
            flip  <= ang_sum[31];
            cx    <= $signed(mul_p[47:14]);
            cy    <= '0;
            cz    <= $signed({{2{ang_f[31]}}, ang_f});
            idx   <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          cx  <= ccw ? cx - ys : cx + ys;
          cy  <= ccw ? cy + xs : cy - xs;
          cz  <= ccw ? cz - at : cz + at;
          idx <= idx + 1'b1;
          if (idx == LAST_STEP) begin
            state <= S_ROT_FIN;
          end
        end
        S_ROT_FIN: begin
          w_vx      <= sat15(rx);
          w_vy      <= sat15(ry);
          mul_a     <= {17'b0, eh_abs};
          mul_b     <= TURN_K;
          mul_start <= 1'b1;
          state     <= S_EH_MUL;
        end
        S_EH_MUL: begin
          if (mul_done) begin
            mul_a     <= mul_p[31:0];
            mul_b     <= theta_gain;
            mul_start <= 1'b1;
            state     <= S_GAIN_MUL;
          end
        end
        S_GAIN_MUL: begin
          if (mul_done) begin
            div_n     <= mul_p + TURN_BIAS;
            div_d     <= DIV_TURN;
            div_start <= 1'b1;
            state     <= S_TR_DIV;
          end
        end
        S_TR_DIV: begin
          if (div_done) begin
            if (eh[15]) begin
              w_tr <= (div_q >= 48'd32768) ? -16'sd32768 : 16'(-div_q[15:0]);
            end else begin
              w_tr <= (div_q > 48'd32767) ? 16'sd32767 : div_q[15:0];
            end
            w_drv <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            status         <= w_status;
            drive_valid    <= w_drv;
            vel_x          <= w_vx;
            vel_y          <= w_vy;
            turn_rate      <= w_tr;
            field_relative <= w_fr;
            done_res       <= fin;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/wfdc_checker.sv
// Port-level checker for the waypoint drive controller, bound to the top level.
// Depends on wfdc_pkg and the assertion macro header.
`include "waypoint_follow_drive_controller_core_assert.svh"

module wfdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic               drive_valid,
  input logic signed [14:0] vel_x,
  input logic signed [14:0] vel_y,
  input logic signed [15:0] turn_rate,
  input logic               field_relative,
  input logic               done_res
);

  `WFDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `WFDC_ASSERT_NOW(a_idle_zero, out_valid && !drive_valid, vel_x == '0 && vel_y == '0 && turn_rate == '0 && !field_relative)
  `WFDC_ASSERT_NOW(a_stop_beat, out_valid && field_relative, drive_valid && !done_res && status == wfdc_pkg::ST_OK)
  `WFDC_ASSERT_NOW(a_err_nodrive, out_valid && status != wfdc_pkg::ST_OK, !drive_valid)

endmodule

bind waypoint_follow_drive_controller_core wfdc_checker u_wfdc_checker (.*);

>>> test/tb_top.sv
// Self-checking bench for waypoint_follow_drive_controller_core: directed table, then
// random waypoint trips checked against an in-bench drive predictor.
// Depends on wfdc_pkg and the core RTL only.
module tb_top;
  import wfdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int NUM_RANDOM     = 400;
  localparam int DEPTH          = 16;
  localparam int STEPS          = 16;
  localparam longint GAIN_K     = 652032874;

  typedef struct packed {
    logic [1:0]         st;
    logic               dv;
    logic signed [14:0] vx;
    logic signed [14:0] vy;
    logic signed [15:0] tr;
    logic               fr;
    logic               dn;
  } drive_res_t;

  typedef struct {
    cmd_t       c;
    int         x;
    int         y;
    int         h;
    int         reps;
    bit         typed;
    drive_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = CMD_LOAD;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic drive_valid;
  logic signed [14:0] vel_x;
  logic signed [14:0] vel_y;
  logic signed [15:0] turn_rate;
  logic field_relative;
  logic done_res;
  logic cfg_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  waypoint_follow_drive_controller_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // drive predictor state
  int way_x [DEPTH];
  int way_y [DEPTH];
  int way_h [DEPTH];
  int unsigned q_head, q_count, path_len, dist_done;
  int tail_x, tail_y, tgt_x, tgt_y, tgt_h, pose_x, pose_y;
  bit arrived;
  int unsigned cruise = 1000;
  int unsigned gain = 256;

  drive_res_t pending_q[$];
  int fail_count = 0;
  int idle_mode = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  const longint arc_tab [STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  function automatic int unsigned span(int ax, int ay, int bx, int by);
    longint dx, dy;
    longint unsigned v, r, b;
    dx = ax - bx;
    dy = ay - by;
    v = dx * dx + dy * dy;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned len_add(int unsigned a, int unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 24'hFFFFFF) ? 24'hFFFFFF : s;
  endfunction

  function automatic int angle_err(int t, int s);
    int a;
    a = t - s;
    if (a > 18000) a -= 36000;
    else if (a < -18000) a += 36000;
    return a;
  endfunction

  function automatic logic [31:0] bearing_of(longint dx, longint dy);
    logic [31:0] z;
    longint x, y, xs, ys;
    z = '0;
    if (dx == 0 && dy == 0) return '0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z = 32'h80000000;
    end
    x = dx * 16384;
    y = dy * 16384;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arc_tab[i][31:0];
      end else begin
        x -= ys; y += xs; z -= arc_tab[i][31:0];
      end
    end
    return z;
  endfunction

  function automatic logic signed [14:0] clip_vel(longint v);
    if (v > 16383) return 15'sd16383;
    if (v < -16384) return -15'sd16384;
    return v[14:0];
  endfunction

  function automatic int unsigned profile_speed();
    if (dist_done >= path_len) return 100;
    if (path_len - dist_done <= 750)
      return (longint'(path_len - dist_done) * cruise) / 750;
    if (dist_done <= 500) return (longint'(dist_done) * cruise) / 500 + 100;
    return cruise;
  endfunction

  function automatic void pop_target();
    tgt_x = way_x[q_head];
    tgt_y = way_y[q_head];
    tgt_h = way_h[q_head];
    q_head = (q_head + 1) % DEPTH;
    q_count--;
  endfunction

  function automatic drive_res_t drive_step(cmd_t c, int x, int y, int h);
    drive_res_t r;
    int ex, ey, eh;
    logic [31:0] hang, alpha, ang;
    bit flip;
    longint rx, ry, rz, xs, ys, num, mag, q;
    r = '0;
    case (c)
      CMD_LOAD: begin
        if (q_count >= DEPTH) r.st = ST_FULL;
        else begin
          if (q_count > 0) path_len = len_add(path_len, span(tail_x, tail_y, x, y));
          way_x[(q_head + q_count) % DEPTH] = x;
          way_y[(q_head + q_count) % DEPTH] = y;
          way_h[(q_head + q_count) % DEPTH] = h;
          q_count++;
          tail_x = x;
          tail_y = y;
        end
      end
      CMD_START: begin
        if (q_count == 0) r.st = ST_EMPTY;
        else pop_target();
      end
      CMD_POSE: begin
        ex = tgt_x - x;
        ey = tgt_y - y;
        eh = angle_err(tgt_h, h);
        if (ex > -100 && ex < 100 && ey > -100 && ey < 100 && eh > -500 && eh < 500) begin
          if (q_count > 0) pop_target();
          else arrived = 1'b1;
        end
        dist_done = len_add(dist_done, span(pose_x, pose_y, x, y));
        if (!arrived) begin
          hang = (longint'(h) * 64'sd4294967296) / 36000;
          alpha = bearing_of(longint'(tgt_x) - x, longint'(tgt_y) - y) - hang;
          ang = alpha + 32'h40000000;
          flip = ang[31];
          ang = flip ? alpha + 32'h80000000 : alpha;
          rz = longint'($signed(ang));
          rx = (longint'(profile_speed()) * GAIN_K) >>> 14;
          ry = 0;
          for (int i = 0; i < STEPS; i++) begin
            xs = rx >>> i;
            ys = ry >>> i;
            if (rz >= 0) begin
              rx -= ys; ry += xs; rz -= arc_tab[i];
            end else begin
              rx += ys; ry -= xs; rz += arc_tab[i];
            end
          end
          rx = (rx + 32768) >>> 16;
          ry = (ry + 32768) >>> 16;
          if (flip) begin
            rx = -rx;
            ry = -ry;
          end
          r.vx = clip_vel(rx);
          r.vy = clip_vel(ry);
          num = longint'(angle_err(tgt_h, h)) * 157 * gain;
          mag = (num < 0) ? -num : num;
          q = (mag + 115200) / 230400;
          if (num < 0) q = -q;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          r.tr = q[15:0];
          r.dv = 1'b1;
        end
        pose_x = x;
        pose_y = y;
      end
      default: begin
        r.dv = 1'b1;
        r.fr = 1'b1;
        dist_done = 0;
        path_len = 0;
        arrived = 1'b0;
      end
    endcase
    r.dn = arrived;
    return r;
  endfunction

  task automatic send_beat(cmd_t c, int x, int y, int h, bit typed, drive_res_t want);
    drive_res_t got;
    while ((idle_mode == 1 && $urandom_range(99) < 66) ||
           (idle_mode == 3 && $urandom_range(99) < 12)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    pos_x <= x[15:0];
    pos_y <= y[15:0];
    heading <= h[15:0];
    do @(posedge clk); while (!in_ready);
    got = drive_step(c, x, y, h);
    pending_q.push_back(typed ? want : got);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_SPEED) cruise = val[12:0];
    else gain = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int wrap_deg(int v);
    return (v > 18000) ? v - 36000 : (v < -18000) ? v + 36000 : v;
  endfunction

  function automatic int any16();
    return $signed(16'($urandom()));
  endfunction

  function automatic int any_heading();
    return $urandom_range(36000) - 18000;
  endfunction

  task automatic random_trip(inout int sent);
    int n, m, bx, by, px, py;
    n = $urandom_range(6, 1);
    if ($urandom_range(3) == 0) begin
      send_beat(CMD_END, any16(), any16(), any_heading(), 1'b0, '0);
      sent++;
    end
    bx = ($urandom_range(7) == 0) ? any16() : $urandom_range(4000) - 2000;
    by = ($urandom_range(7) == 0) ? any16() : $urandom_range(4000) - 2000;
    for (int i = 0; i < n; i++) begin
      send_beat(CMD_LOAD, bx, by, any_heading(), 1'b0, '0);
      bx = clamp16(bx + $urandom_range(1600) - 800);
      by = clamp16(by + $urandom_range(1600) - 800);
      sent++;
    end
    send_beat(CMD_START, any16(), any16(), any_heading(), 1'b0, '0);
    sent++;
    m = $urandom_range(15, 4);
    for (int i = 0; i < m; i++) begin
      case ($urandom_range(9))
        0: send_beat(cmd_t'($urandom_range(3)), any16(), any16(), any_heading(), 1'b0, '0);
        1, 2, 3, 4: send_beat(CMD_POSE, clamp16(tgt_x + $urandom_range(198) - 99),
                              clamp16(tgt_y + $urandom_range(198) - 99),
                              wrap_deg(tgt_h + $urandom_range(998) - 499), 1'b0, '0);
        default: begin
          px = clamp16(pose_x + (tgt_x - pose_x) / 2 + $urandom_range(300) - 150);
          py = clamp16(pose_y + (tgt_y - pose_y) / 2 + $urandom_range(300) - 150);
          send_beat(CMD_POSE, px, py, any_heading(), 1'b0, '0);
        end
      endcase
      sent++;
    end
  endtask

  stim_row_t dir_rows [$] = '{
    '{CMD_POSE,  0, 0, 0, 1, 1'b1, '{ST_OK, 1'b0, 15'sd0, 15'sd0, 16'sd0, 1'b0, 1'b1}},
    '{CMD_END,   0, 0, 0, 1, 1'b1, '{ST_OK, 1'b1, 15'sd0, 15'sd0, 16'sd0, 1'b1, 1'b0}},
    '{CMD_START, 5, 5, 5, 1, 1'b1, '{ST_EMPTY, 1'b0, 15'sd0, 15'sd0, 16'sd0, 1'b0, 1'b0}},
    '{CMD_POSE, 300, -200, 9000, 1, 1'b0, '0},
    '{CMD_LOAD, 32767, 32767, 18000, 1, 1'b1, '0},
    '{CMD_LOAD, -32768, -32768, -18000, 1, 1'b1, '0},
    '{CMD_LOAD, 0, 0, 0, 1, 1'b1, '0},
    '{CMD_START, 0, 0, 0, 1, 1'b1, '0},
    '{CMD_POSE, -32768, 32767, -18000, 1, 1'b0, '0},
    '{CMD_POSE, 32700, 32700, -17800, 1, 1'b0, '0},
    '{CMD_POSE, -32700, -32700, 17600, 1, 1'b0, '0},
    '{CMD_POSE, 40, -60, 300, 1, 1'b0, '0},
    '{CMD_POSE, 0, 0, 0, 1, 1'b0, '0},
    '{CMD_POSE, 1200, -800, 4500, 1, 1'b0, '0},
    '{CMD_END, 0, 0, 0, 1, 1'b1, '{ST_OK, 1'b1, 15'sd0, 15'sd0, 16'sd0, 1'b1, 1'b0}},
    '{CMD_LOAD, 100, 200, 1000, 16, 1'b0, '0},
    '{CMD_LOAD, 1, 2, 3, 1, 1'b1, '{ST_FULL, 1'b0, 15'sd0, 15'sd0, 16'sd0, 1'b0, 1'b0}},
    '{CMD_START, 0, 0, 0, 1, 1'b0, '0},
    '{CMD_POSE, 150, 250, -16000, 1, 1'b0, '0},
    '{CMD_POSE, 100, 200, 1000, 1, 1'b0, '0},
    '{CMD_END, 0, 0, 0, 1, 1'b0, '0}
  };

  always @(posedge clk) begin
    drive_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (status !== want.st) begin
          $error("status exp %0d got %0d", want.st, status); fail_count++;
        end
        if (drive_valid !== want.dv) begin
          $error("drive_valid exp %0d got %0d", want.dv, drive_valid); fail_count++;
        end
        if (vel_x !== want.vx) begin
          $error("vel_x exp %0d got %0d", want.vx, vel_x); fail_count++;
        end
        if (vel_y !== want.vy) begin
          $error("vel_y exp %0d got %0d", want.vy, vel_y); fail_count++;
        end
        if (turn_rate !== want.tr) begin
          $error("turn_rate exp %0d got %0d", want.tr, turn_rate); fail_count++;
        end
        if (field_relative !== want.fr) begin
          $error("field_relative exp %0d got %0d", want.fr, field_relative); fail_count++;
        end
        if (done_res !== want.dn) begin
          $error("done_res exp %0d got %0d", want.dn, done_res); fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == 2) out_ready <= ($urandom_range(99) >= 66);
    else if (idle_mode == 3) out_ready <= ($urandom_range(99) >= 12);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sent;
    q_head = 0; q_count = 0; path_len = 0; dist_done = 0;
    tail_x = 0; tail_y = 0; tgt_x = 0; tgt_y = 0; tgt_h = 0;
    pose_x = 0; pose_y = 0; arrived = 1'b0;
    foreach (way_x[i]) begin
      way_x[i] = 0; way_y[i] = 0; way_h[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_MAX_SPEED, 16'd1000);
    write_reg(REG_THETA_GAIN, 16'd256);
    foreach (dir_rows[i])
      repeat (dir_rows[i].reps)
        send_beat(dir_rows[i].c, dir_rows[i].x, dir_rows[i].y, dir_rows[i].h,
                  dir_rows[i].typed, dir_rows[i].res);
    drain();
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(REG_MAX_SPEED, 16'd8000); write_reg(REG_THETA_GAIN, 16'hFFFF); end
        1: begin write_reg(REG_MAX_SPEED, 16'd0); write_reg(REG_THETA_GAIN, 16'd0); end
        2: begin
          write_reg(REG_MAX_SPEED, $urandom_range(8000));
          write_reg(REG_THETA_GAIN, $urandom_range(65535));
        end
        default: begin write_reg(REG_MAX_SPEED, 16'd1000); write_reg(REG_THETA_GAIN, 16'd256); end
      endcase
      idle_mode = ph;
      if (ph == 1) hold_cycles = 1500;
      while (sent < (ph + 1) * NUM_RANDOM / 4) random_trip(sent);
      drain();
    end
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/wfdc_pkg.sv
rtl/core/wfdc_smul.sv
rtl/core/wfdc_sdiv.sv
rtl/core/waypoint_follow_drive_controller_core.sv
rtl/core/wfdc_checker.sv
test/tb_top.sv
